// ----- rtl/core/ple_pkg.sv -----
package ple_pkg;

  localparam int unsigned DEF_CAPACITY = 32;
  localparam int unsigned KIND_W       = 3;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned LEN_W        = 6;

  // input kind codes
  localparam logic [KIND_W-1:0] KIND_INS_FIRST = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_LAST  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_AT    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEL_FIRST = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEL_LAST  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DEL_AT    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_READ      = 3'd6;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd7;

  typedef enum logic [1:0] {
    OP_INS   = 2'd0,
    OP_DEL   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    WHERE_FIRST = 2'd0,
    WHERE_LAST  = 2'd1,
    WHERE_AT    = 2'd2
  } where_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // decoded command handed from front to back
  typedef struct packed {
    op_t                       op;
    where_t                    where;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } cmd_t;

endpackage

// ----- rtl/core/ple_front.sv -----
module ple_front import ple_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [KIND_W-1:0]         in_kind,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [POS_W-1:0]          in_position,
  output logic                      cmd_valid,
  output cmd_t                      cmd,
  input  logic                      cmd_pop
);

  cmd_t       dec;
  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  // decode kind into operation and place
  always_comb begin
    dec.value    = in_value;
    dec.position = in_position;
    dec.op       = OP_READ;
    dec.where    = WHERE_FIRST;
    case (in_kind)
      KIND_INS_FIRST: begin dec.op = OP_INS; dec.where = WHERE_FIRST; end
      KIND_INS_LAST:  begin dec.op = OP_INS; dec.where = WHERE_LAST;  end
      KIND_INS_AT:    begin dec.op = OP_INS; dec.where = WHERE_AT;    end
      KIND_DEL_FIRST: begin dec.op = OP_DEL; dec.where = WHERE_FIRST; end
      KIND_DEL_LAST:  begin dec.op = OP_DEL; dec.where = WHERE_LAST;  end
      KIND_DEL_AT:    begin dec.op = OP_DEL; dec.where = WHERE_AT;    end
      KIND_READ:      dec.op = OP_READ;
      KIND_CLEAR:     dec.op = OP_CLEAR;
      default:        dec.op = OP_READ;
    endcase
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  // two-entry command queue
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (cmd_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

// ----- rtl/core/ple_back.sv -----
module ple_back import ple_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  input  cmd_t                       cmd,
  output logic                       cmd_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [VALUE_W-1:0]  out_element,
  output logic                       out_is_last,
  output logic [LEN_W-1:0]           out_length
);

  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_INS_WALK = 6'b000010,
    S_INS_LINK = 6'b000100,
    S_DEL_WALK = 6'b001000,
    S_DEL_LINK = 6'b010000,
    S_READ     = 6'b100000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [SW-1:0]             cur_r, cur_nxt, prev_r, prev_nxt, first_r, first_nxt;
  logic [AW-1:0]             steps_r, steps_nxt;
  logic                      head_r, head_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic [CW-1:0]             count_r, count_nxt, sp_r, sp_nxt, fresh_r, fresh_nxt;

  // node store and free stack
  logic signed [VALUE_W-1:0] vmem [CAPACITY];
  logic [SW-1:0]             lmem [CAPACITY];
  logic [SW-1:0]             fmem [CAPACITY];
  logic signed [VALUE_W-1:0] vq_r;
  logic [SW-1:0]             lq_r, fq_r;
  logic                      v_we, l_we, f_we;
  logic [SW-1:0]             v_wa, l_wa, l_wd, f_wd, alloc;

  // result register
  logic                      out_valid_r;
  status_t                   out_status_r;
  logic signed [VALUE_W-1:0] out_element_r;
  logic                      out_is_last_r;
  logic [LEN_W-1:0]          out_length_r;

  logic                      out_free, emit, e_last;
  status_t                   e_status;
  logic signed [VALUE_W-1:0] e_element;
  logic [CW-1:0]             e_len;

  logic [AW-1:0]             n, pos, ins_at, del_at;
  status_t                   ins_st, del_st;

  assign out_free = !out_valid_r || !out_stall;
  assign alloc    = (sp_r != '0) ? fq_r : fresh_r[SW-1:0];
  assign n        = AW'(count_r);
  assign pos      = AW'(cmd.position);

  // status checks for the command at the queue head
  always_comb begin
    ins_st = ST_OK;
    ins_at = AW'(1);
    case (cmd.where)
      WHERE_FIRST: ins_at = AW'(1);
      WHERE_LAST:  ins_at = n + AW'(1);
      default: begin
        ins_at = pos;
        if (n == '0 && pos != AW'(1)) ins_st = ST_EMPTY;
        else if (pos == '0 || pos > n + AW'(1)) ins_st = ST_INVALID;
      end
    endcase
    if (ins_st == ST_OK && count_r == CW'(CAPACITY)) ins_st = ST_FULL;

    del_st = ST_OK;
    del_at = AW'(1);
    case (cmd.where)
      WHERE_FIRST: del_at = AW'(1);
      WHERE_LAST:  del_at = n;
      default: begin
        del_at = pos;
        if (pos == '0 || pos > n) del_st = ST_INVALID;
      end
    endcase
    if (n == '0) del_st = ST_EMPTY;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    first_nxt = first_r;
    steps_nxt = steps_r;
    head_nxt  = head_r;
    val_nxt   = val_r;
    count_nxt = count_r;
    sp_nxt    = sp_r;
    fresh_nxt = fresh_r;
    cmd_pop   = 1'b0;
    emit      = 1'b0;
    e_status  = ST_OK;
    e_element = '0;
    e_last    = 1'b1;
    e_len     = count_r;
    v_we = 1'b0; v_wa = alloc;
    l_we = 1'b0; l_wa = alloc; l_wd = first_r;
    f_we = 1'b0; f_wd = cur_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          cur_nxt = first_r;
          val_nxt = cmd.value;
          case (cmd.op)
            OP_INS: begin
              if (ins_st != ST_OK) begin
                emit = 1'b1; e_status = ins_st;
              end else begin
                head_nxt  = (ins_at == AW'(1));
                steps_nxt = ins_at - AW'(2);
                state_nxt = S_INS_WALK;
              end
            end
            OP_DEL: begin
              if (del_st != ST_OK) begin
                emit = 1'b1; e_status = del_st;
              end else begin
                head_nxt  = (del_at == AW'(1));
                steps_nxt = del_at - AW'(2);
                state_nxt = (del_at == AW'(1)) ? S_DEL_LINK : S_DEL_WALK;
              end
            end
            OP_READ: begin
              if (n == '0) begin
                emit = 1'b1; e_status = ST_EMPTY;
              end else begin
                steps_nxt = n - AW'(1);
                state_nxt = S_READ;
              end
            end
            OP_CLEAR: begin
              emit = 1'b1;
              e_len = '0;
              if (n == '0) begin
                e_status = ST_EMPTY;
              end else begin
                count_nxt = '0;
                sp_nxt    = '0;
                fresh_nxt = '0;
              end
            end
            default: emit = 1'b0;
          endcase
        end
      end
      // walk to the predecessor, then fill the new node
      S_INS_WALK: begin
        if (head_r || steps_r == '0) begin
          v_we = 1'b1;
          l_we = 1'b1;
          l_wd = head_r ? first_r : lq_r;
          state_nxt = S_INS_LINK;
        end else begin
          cur_nxt   = lq_r;
          steps_nxt = steps_r - AW'(1);
        end
      end
      // hook the new node in and take its slot
      S_INS_LINK: begin
        if (out_free) begin
          if (head_r) begin
            first_nxt = alloc;
          end else begin
            l_we = 1'b1; l_wa = cur_r; l_wd = alloc;
          end
          if (sp_r != '0) sp_nxt = sp_r - CW'(1);
          else fresh_nxt = fresh_r + CW'(1);
          count_nxt = count_r + CW'(1);
          emit  = 1'b1;
          e_len = count_r + CW'(1);
          state_nxt = S_IDLE;
        end
      end
      S_DEL_WALK: begin
        cur_nxt = lq_r;
        if (steps_r == '0) begin
          prev_nxt  = cur_r;
          state_nxt = S_DEL_LINK;
        end else begin
          steps_nxt = steps_r - AW'(1);
        end
      end
      // unlink the victim and push its slot
      S_DEL_LINK: begin
        if (out_free) begin
          if (head_r) begin
            first_nxt = lq_r;
          end else begin
            l_we = 1'b1; l_wa = prev_r; l_wd = lq_r;
          end
          f_we = 1'b1;
          sp_nxt    = sp_r + CW'(1);
          count_nxt = count_r - CW'(1);
          emit  = 1'b1;
          e_len = count_r - CW'(1);
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          emit      = 1'b1;
          e_element = vq_r;
          e_last    = (steps_r == '0);
          if (steps_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            cur_nxt   = lq_r;
            steps_nxt = steps_r - AW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memories: one write port each, registered reads
  always_ff @(posedge clk) begin
    if (v_we) vmem[v_wa] <= val_r;
    if (l_we) lmem[l_wa] <= l_wd;
    if (f_we) fmem[sp_r[SW-1:0]] <= f_wd;
    vq_r <= vmem[cur_nxt];
    lq_r <= lmem[cur_nxt];
    fq_r <= fmem[SW'(sp_r - CW'(1))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sp_r        <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sp_r        <= sp_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= emit || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    first_r <= first_nxt;
    steps_r <= steps_nxt;
    head_r  <= head_nxt;
    val_r   <= val_nxt;
    if (emit) begin
      out_status_r  <= e_status;
      out_element_r <= e_element;
      out_is_last_r <= e_last;
      out_length_r  <= LEN_W'(e_len);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_is_last = out_is_last_r;
  assign out_length  = out_length_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY)) else $error("element count above capacity");
  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (AW'(fresh_r) == AW'(sp_r) + AW'(count_r)))
    else $error("free stack and fresh slots disagree with count");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == S_IDLE) && cmd_valid) else $error("pop outside idle");
  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (steps_r < AW'(count_r)))
    else $error("read-out runs past list end");

endmodule

// ----- rtl/core/positional_list_engine.sv -----
// Ordered list of up to CAPACITY signed 32-bit values held as a singly linked
// list in on-chip node memories, with freed slots kept on a stack. A front end
// decodes each item into a two-entry command queue; a back end sequencer walks
// the links one node per cycle, and takes the next item from the queue only once
// it is back in idle. An insert walks to the predecessor where there is one,
// fills the new node and then links it in; a delete walks to the predecessor
// where there is one and unlinks the victim; a read-out gives one result per
// cycle when the output is not stalled; an error or a clear is answered straight
// from idle. The walk is serial, as the link memory has a single read port.
// No clearing pass is needed after reset.
module positional_list_engine import ple_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [KIND_W-1:0]         in_kind,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [POS_W-1:0]          in_position,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [STATUS_W-1:0]       out_status,
  output logic signed [VALUE_W-1:0] out_element,
  output logic                      out_is_last,
  output logic [LEN_W-1:0]          out_length
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  ple_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_value    (in_value),
    .in_position (in_position),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  ple_back #(.CAPACITY(CAPACITY)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_element (out_element),
    .out_is_last (out_is_last),
    .out_length  (out_length)
  );

endmodule

// ----- tb/ple_checker.sv -----
module ple_checker import ple_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [KIND_W-1:0]         in_kind,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [POS_W-1:0]          in_position,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [STATUS_W-1:0]       out_status,
  input  logic signed [VALUE_W-1:0] out_element,
  input  logic                      out_is_last,
  input  logic [LEN_W-1:0]          out_length,
  output int                        fail_count,
  output int                        pending
);

  localparam int CAP = DEF_CAPACITY;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] element;
    logic                      is_last;
    logic [LEN_W-1:0]          length;
  } result_t;

  // shadow list kept as a plain ordered array
  logic signed [VALUE_W-1:0] list_vals[$];
  result_t                   want_q[$];
  int                        mismatches;

  assign pending = want_q.size();

  function automatic result_t mk(status_t st, logic signed [VALUE_W-1:0] el,
                                 logic last);
    result_t r;
    r.status  = st;
    r.element = el;
    r.is_last = last;
    r.length  = LEN_W'(list_vals.size());
    return r;
  endfunction

  // apply one item to the shadow list and queue its results
  task automatic apply_item(logic [KIND_W-1:0] k, logic signed [VALUE_W-1:0] v,
                            logic [POS_W-1:0] p);
    int n;
    int at;
    status_t st;
    n  = list_vals.size();
    st = ST_OK;
    case (k)
      KIND_INS_FIRST, KIND_INS_LAST, KIND_INS_AT: begin
        at = (k == KIND_INS_FIRST) ? 1 : (k == KIND_INS_LAST) ? n + 1 : int'(p);
        if (k == KIND_INS_AT && n == 0 && p != 1) st = ST_EMPTY;
        else if (at < 1 || at > n + 1) st = ST_INVALID;
        else if (n >= CAP) st = ST_FULL;
        else list_vals.insert(at - 1, v);
      end
      KIND_DEL_FIRST, KIND_DEL_LAST, KIND_DEL_AT: begin
        at = (k == KIND_DEL_FIRST) ? 1 : (k == KIND_DEL_LAST) ? n : int'(p);
        if (n == 0) st = ST_EMPTY;
        else if (at < 1 || at > n) st = ST_INVALID;
        else list_vals.delete(at - 1);
      end
      KIND_READ: begin
        if (n == 0) st = ST_EMPTY;
        else begin
          for (int i = 0; i < n; i++) want_q.push_back(mk(ST_OK, list_vals[i], i == n - 1));
          return;
        end
      end
      default: begin
        if (n == 0) st = ST_EMPTY;
        else list_vals.delete();
      end
    endcase
    want_q.push_back(mk(st, '0, 1'b1));
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      fail_count <= 0;
      mismatches = 0;
      list_vals.delete();
      want_q.delete();
    end else begin
      if (in_valid && !in_stall) apply_item(in_kind, in_value, in_position);
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: status %0d element %0d",
                                         out_status, out_element);
        end else begin
          want = want_q.pop_front();
          if (out_status !== want.status || out_element !== want.element ||
              out_is_last !== want.is_last || out_length !== want.length) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d el=%0d last=%0d len=%0d got st=%0d el=%0d last=%0d len=%0d",
                       want.status, want.element, want.is_last, want.length,
                       out_status, out_element, out_is_last, out_length);
          end
        end
      end
      fail_count <= mismatches;
    end
  end

endmodule

// ----- tb/tb_positional_list_engine.sv -----
module tb_positional_list_engine;
  import ple_pkg::*;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [KIND_W-1:0]         in_kind;
  logic signed [VALUE_W-1:0] in_value;
  logic [POS_W-1:0]          in_position;
  logic                      out_valid;
  logic                      out_stall;
  logic [STATUS_W-1:0]       out_status;
  logic signed [VALUE_W-1:0] out_element;
  logic                      out_is_last;
  logic [LEN_W-1:0]          out_length;
  int                        fail_count;
  int                        pending;
  int                        cycles;
  int                        list_len;
  bit                        hold_rx;

  positional_list_engine uut (.*);

  ple_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("status: fail");
      $finish;
    end
  end

  // gap length: mostly short, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stall; a long hold-off when hold_rx is raised
  initial begin
    int g;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
        hold_rx = 0;
      end else if (cycles > 3000 && cycles < 6000) out_stall <= 1'b0;
      else begin
        g = gap_len();
        if (g == 0) out_stall <= 1'b0;
        else begin
          out_stall <= 1'b1;
          repeat (g - 1) @(posedge clk);
        end
      end
    end
  end

  task automatic send(logic [KIND_W-1:0] k, logic signed [VALUE_W-1:0] v,
                      logic [POS_W-1:0] p);
    in_valid    <= 1'b1;
    in_kind     <= k;
    in_value    <= v;
    in_position <= p;
    do @(posedge clk); while (in_stall);
    // track the length loosely to aim positions
    case (k)
      KIND_INS_FIRST, KIND_INS_LAST: if (list_len < DEF_CAPACITY) list_len++;
      KIND_INS_AT: if (p >= 1 && p <= list_len + 1 && list_len < DEF_CAPACITY) list_len++;
      KIND_DEL_FIRST, KIND_DEL_LAST: if (list_len > 0) list_len--;
      KIND_DEL_AT: if (p >= 1 && p <= list_len) list_len--;
      KIND_CLEAR: list_len = 0;
      default: ;
    endcase
  endtask

  task automatic idle_gap();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] rnd_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int k;
    int p;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_kind     = KIND_READ;
    in_value    = '0;
    in_position = '0;
    cycles      = 0;
    list_len    = 0;
    hold_rx     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-list cases, extremes, every kind
    send(KIND_READ, 0, 0);
    send(KIND_CLEAR, 0, 0);
    send(KIND_DEL_FIRST, 0, 0);
    send(KIND_DEL_LAST, 0, 0);
    send(KIND_DEL_AT, 0, 1);
    send(KIND_INS_AT, 5, 2);
    send(KIND_INS_AT, 32'sh7fffffff, 1);
    send(KIND_INS_FIRST, 32'sh80000000, 127);
    send(KIND_INS_LAST, -1, 0);
    send(KIND_INS_AT, 32'sh55555555, 4);
    send(KIND_INS_AT, 32'shaaaaaaaa, 0);
    send(KIND_INS_AT, 9, 127);
    send(KIND_INS_AT, 10, 2);
    send(KIND_READ, 0, 0);
    send(KIND_DEL_AT, 0, 0);
    send(KIND_DEL_AT, 0, 6);
    send(KIND_DEL_AT, 0, 5);
    send(KIND_DEL_AT, 0, 2);
    send(KIND_DEL_LAST, 0, 0);
    send(KIND_DEL_FIRST, 0, 0);
    send(KIND_READ, 0, 0);
    send(KIND_CLEAR, 0, 0);

    // fill past capacity while the receiver holds off
    hold_rx = 1;
    for (int i = 0; i < 34; i++) send(KIND_INS_LAST, $urandom, 0);
    send(KIND_INS_FIRST, 1, 0);
    send(KIND_INS_AT, 2, 7'd33);
    send(KIND_READ, 0, 0);

    // sender pauses until everything has drained
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // random part
    for (int i = 0; i < 220; i++) begin
      p = $urandom_range(0, 99);
      if (p < 40) k = $urandom_range(0, 2);
      else if (p < 70) k = $urandom_range(3, 5);
      else if (p < 85) k = int'(KIND_READ);
      else if (p < 88) k = int'(KIND_CLEAR);
      else k = $urandom_range(0, 7);
      if ($urandom_range(0, 9) < 8) p = $urandom_range(0, list_len + 2);
      else p = $urandom_range(0, 127);
      send(KIND_W'(k), rnd_value(), POS_W'(p));
      idle_gap();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ple_pkg.sv
rtl/core/ple_front.sv
rtl/core/ple_back.sv
rtl/core/positional_list_engine.sv
tb/ple_checker.sv
tb/tb_positional_list_engine.sv
